@@ rtl/hps_pkg.sv @@
// shared types and constants for the handle pool free stack unit
// no dependencies

package hps_pkg;

	localparam int POOL_DEPTH_DEF = 256;
	localparam int KIND_W = 2;
	localparam int HANDLE_W = 8;
	localparam int SIZE_W = 9;
	localparam int STATUS_W = 2;
	localparam logic [SIZE_W-1:0] POOL_SIZE_RST = SIZE_W'(256);

	typedef enum logic [KIND_W-1:0] {
		KIND_OBTAIN   = 2'd0,
		KIND_RELEASE  = 2'd1,
		KIND_FREE_ALL = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_EXHAUSTED = 2'd1,
		STS_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		PH_IDLE = 1'b0,
		PH_READ = 1'b1
	} phase_t;

endpackage

@@ rtl/hps_if.sv @@
// channel interfaces for request, response and configuration transactions
// depends on hps_pkg

interface hps_in_if;
	import hps_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [HANDLE_W-1:0] handle;
	modport source (output valid, output kind, output handle, input ready);
	modport sink (input valid, input kind, input handle, output ready);
endinterface

interface hps_out_if;
	import hps_pkg::*;
	logic                valid;
	logic                ready;
	logic [HANDLE_W-1:0] granted_handle;
	logic [STATUS_W-1:0] status;
	logic [SIZE_W-1:0]   in_use;
	modport source (output valid, output granted_handle, output status, output in_use,
		input ready);
	modport sink (input valid, input granted_handle, input status, input in_use,
		output ready);
endinterface

interface hps_cfg_if;
	import hps_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] pool_size;
	modport source (output valid, output pool_size, input ready);
	modport sink (input valid, input pool_size, output ready);
endinterface

@@ rtl/handle_pool_free_stack_unit.sv @@
// handle allocator kept as a stack of free handle indices in one synchronous memory
// depends on hps_pkg and the channel interfaces in hps_if.sv
// Release, free all, an unused kind, an exhausted obtain and an obtain at a slot
// not yet reached since the last free all are answered from the idle phase; an
// obtain at a slot already reached first reads the stack memory in the read phase
// and takes no new request meanwhile. A high-water mark of the top pointer stands
// in for restoring the stack; free all and reset need no clearing pass. The
// response register lets a new request in during the cycle its held result is taken.

module handle_pool_free_stack_unit
	import hps_pkg::*;
#(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hps_cfg_if.sink   cfg,
	hps_in_if.sink    req,
	hps_out_if.source rsp
);

	localparam int TW = $clog2(POOL_DEPTH + 1);
	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = (TW > SIZE_W) ? TW : SIZE_W;

	logic [HANDLE_W-1:0] mem [POOL_DEPTH];
	logic [HANDLE_W-1:0] rd_data_q;

	phase_t              phase_q, phase_d;
	logic [TW-1:0]       top_q, top_d;
	logic [TW-1:0]       hwm_q, hwm_d;
	logic [SIZE_W-1:0]   pool_size_q;
	logic                out_valid_q, out_valid_d;
	logic [HANDLE_W-1:0] granted_q, granted_d;
	status_t             status_q, status_d;
	logic [SIZE_W-1:0]   in_use_q, in_use_d;

	logic                mem_we, mem_re;
	logic [AW-1:0]       wr_addr, rd_addr;
	logic [TW-1:0]       top_inc, top_dec;
	logic                can_obtain, in_fire;

	assign cfg.ready = 1'b1;
	assign req.ready = (phase_q == PH_IDLE) && (!out_valid_q || rsp.ready);
	assign in_fire   = req.valid && req.ready;

	assign rsp.valid          = out_valid_q;
	assign rsp.granted_handle = granted_q;
	assign rsp.status         = status_q;
	assign rsp.in_use         = in_use_q;

	assign top_inc    = top_q + 1'b1;
	assign top_dec    = top_q - 1'b1;
	assign can_obtain = (CW'(top_q) < CW'(pool_size_q)) && (CW'(top_q) < CW'(POOL_DEPTH));
	assign rd_addr    = top_q[AW-1:0];
	assign wr_addr    = top_dec[AW-1:0];

	always_comb begin
		phase_d     = phase_q;
		top_d       = top_q;
		hwm_d       = hwm_q;
		out_valid_d = out_valid_q && !rsp.ready;
		granted_d   = granted_q;
		status_d    = status_q;
		in_use_d    = in_use_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (in_fire) begin
					granted_d = '0;
					status_d  = STS_OK;
					case (kind_t'(req.kind))
						KIND_OBTAIN: begin
							if (!can_obtain) begin
								status_d    = STS_EXHAUSTED;
								out_valid_d = 1'b1;
							end else if (top_q == hwm_q) begin
								// slot untouched since restore holds its own index
								granted_d   = HANDLE_W'(top_q);
								top_d       = top_inc;
								hwm_d       = top_inc;
								out_valid_d = 1'b1;
							end else begin
								mem_re  = 1'b1;
								phase_d = PH_READ;
							end
						end
						KIND_RELEASE: begin
							if (top_q == '0) begin
								status_d = STS_UNDERFLOW;
							end else begin
								top_d  = top_dec;
								mem_we = 1'b1;
							end
							out_valid_d = 1'b1;
						end
						KIND_FREE_ALL: begin
							top_d       = '0;
							hwm_d       = '0;
							out_valid_d = 1'b1;
						end
						default: begin
							out_valid_d = 1'b1;
						end
					endcase
					in_use_d = SIZE_W'(top_d);
				end
			end
			PH_READ: begin
				granted_d   = rd_data_q;
				status_d    = STS_OK;
				top_d       = top_inc;
				in_use_d    = SIZE_W'(top_inc);
				out_valid_d = 1'b1;
				phase_d     = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			top_q       <= '0;
			hwm_q       <= '0;
			pool_size_q <= POOL_SIZE_RST;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			top_q       <= top_d;
			hwm_q       <= hwm_d;
			out_valid_q <= out_valid_d;
			if (cfg.valid && cfg.ready) begin
				pool_size_q <= cfg.pool_size;
			end
		end
	end

	always_ff @(posedge clk) begin
		granted_q <= granted_d;
		status_q  <= status_d;
		in_use_q  <= in_use_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= req.handle;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	a_top_below_hwm: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= hwm_q)
		else $error("top pointer above high-water mark");

	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(hwm_q) <= CW'(POOL_DEPTH))
		else $error("high-water mark beyond stack depth");

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_READ |=> out_valid_q && status_q == STS_OK
			&& in_use_q == SIZE_W'(top_q))
		else $error("memory read did not complete an obtain");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> phase_q == PH_READ && !out_valid_q)
		else $error("obtain read overlaps a pending response");

endmodule

@@ sim/handle_pool_free_stack_unit_tb.sv @@
// self-checking testbench for the handle pool free stack unit: directed and random
// obtain, release and free-all transactions checked against a predictor of the stack
// depends on hps_pkg, the channel interfaces in rtl/hps_if.sv and the unit itself

module handle_pool_free_stack_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hps_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 60;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] handle;
	} request_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] granted_handle;
		status_t             status;
		logic [SIZE_W-1:0]   in_use;
	} grant_t;

	typedef enum {LEAN_OBTAIN, LEAN_RELEASE, LEAN_MIXED} lean_t;

	logic clk = 1'b0;
	logic arst_n;

	hps_cfg_if cfg_ch();
	hps_in_if  req_ch();
	hps_out_if rsp_ch();

	handle_pool_free_stack_unit #(
		.POOL_DEPTH(POOL_DEPTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [HANDLE_W-1:0] free_slots [POOL_DEPTH_DEF];
	int unsigned         slot_top;
	logic [SIZE_W-1:0]   pool_size_model;

	request_t request_queue [$];
	grant_t   pending_grants [$];

	int unsigned req_offered = 0;
	int unsigned req_taken = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned hold_token = 0;
	int unsigned hold_seen = 0;
	bit          idle_en = 1'b1;

	int unsigned fail_count = 0;
	int unsigned checked_ok = 0;
	int unsigned exhausted_seen = 0;
	int unsigned underflow_seen = 0;
	int unsigned cfg_writes = 0;

	function automatic void restore_free_slots();
		for (int i = 0; i < POOL_DEPTH_DEF; i++) begin
			free_slots[i] = HANDLE_W'(i);
		end
		slot_top = 0;
	endfunction

	function automatic grant_t predict_grant(logic [KIND_W-1:0] kind,
		logic [HANDLE_W-1:0] handle);
		grant_t      g;
		int unsigned limit;
		g.granted_handle = '0;
		g.status = STS_OK;
		limit = (pool_size_model > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : pool_size_model;
		case (kind)
			KIND_OBTAIN: begin
				if (slot_top < limit) begin
					g.granted_handle = free_slots[slot_top];
					slot_top++;
				end else begin
					g.status = STS_EXHAUSTED;
				end
			end
			KIND_RELEASE: begin
				if (slot_top == 0) begin
					g.status = STS_UNDERFLOW;
				end else begin
					slot_top--;
					free_slots[slot_top] = handle;
				end
			end
			KIND_FREE_ALL: begin
				restore_free_slots();
			end
			default: begin
			end
		endcase
		g.in_use = SIZE_W'(slot_top);
		return g;
	endfunction

	// sender
	always @(negedge clk) begin
		request_t next_req;
		if (arst_n && (!req_ch.valid || req_taken == req_offered)) begin
			if (send_gap > 0) begin
				req_ch.valid <= 1'b0;
				send_gap--;
			end else if (request_queue.size() > 0) begin
				next_req = request_queue.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= next_req.kind;
				req_ch.handle <= next_req.handle;
				req_offered++;
				if (idle_en && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(1, 16);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (idle_en && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 16);
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		grant_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_grants.size() == 0) begin
					$display("%0t ns: unexpected transaction, expected none, got handle %0d status %0d in_use %0d",
						$time, rsp_ch.granted_handle, rsp_ch.status, rsp_ch.in_use);
					fail_count++;
				end else begin
					want = pending_grants.pop_front();
					if (rsp_ch.granted_handle !== want.granted_handle) begin
						$display("%0t ns: granted_handle expected %0d, got %0d",
							$time, want.granted_handle, rsp_ch.granted_handle);
						fail_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$display("%0t ns: status expected %0d, got %0d",
							$time, want.status, rsp_ch.status);
						fail_count++;
					end
					if (rsp_ch.in_use !== want.in_use) begin
						$display("%0t ns: in_use expected %0d, got %0d",
							$time, want.in_use, rsp_ch.in_use);
						fail_count++;
					end
					checked_ok++;
					if (want.status == STS_EXHAUSTED) exhausted_seen++;
					if (want.status == STS_UNDERFLOW) underflow_seen++;
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				pool_size_model = cfg_ch.pool_size;
				cfg_writes++;
			end
			if (req_ch.valid && req_ch.ready) begin
				pending_grants.push_back(predict_grant(req_ch.kind, req_ch.handle));
				req_taken++;
			end
		end
	end

	task automatic queue_request(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle);
		request_t r;
		r.kind = kind;
		r.handle = handle;
		request_queue.push_back(r);
	endtask

	task automatic wait_drained();
		while (request_queue.size() != 0 || req_taken != req_offered ||
			pending_grants.size() != 0) @(posedge clk);
	endtask

	task automatic set_pool_size(logic [SIZE_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.pool_size <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic queue_segment(int unsigned count, lean_t lean);
		int unsigned roll;
		int unsigned pick;
		logic [HANDLE_W-1:0] h;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			pick = $urandom_range(0, 9);
			h = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : HANDLE_W'($urandom_range(0, 255));
			if (roll < 1) begin
				queue_request(KIND_UNUSED, h);
			end else if (roll < 3) begin
				queue_request(KIND_FREE_ALL, h);
			end else begin
				roll = $urandom_range(0, 99);
				case (lean)
					LEAN_OBTAIN: queue_request((roll < 90) ? KIND_OBTAIN : KIND_RELEASE, h);
					LEAN_RELEASE: queue_request((roll < 90) ? KIND_RELEASE : KIND_OBTAIN, h);
					default: queue_request((roll < 50) ? KIND_OBTAIN : KIND_RELEASE, h);
				endcase
			end
		end
	endtask

	initial begin
		logic [SIZE_W-1:0] size_plan [PHASES];
		int unsigned       phase_count;
		int unsigned       seg_len;
		size_plan = '{9'd256, 9'd3, 9'd1, 9'd0, 9'd511, 9'd16, 9'd2, 9'd257, 9'd255,
			9'd64, 9'd0, 9'd8};
		size_plan[10] = SIZE_W'($urandom_range(1, 256));
		restore_free_slots();
		pool_size_model = POOL_SIZE_RST;
		cfg_ch.valid = 1'b0;
		cfg_ch.pool_size = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.handle = '0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: default pool size
		queue_request(KIND_RELEASE, 8'hFF);
		queue_request(KIND_UNUSED, 8'hFF);
		queue_request(KIND_OBTAIN, 8'hA5);
		queue_request(KIND_OBTAIN, 8'h00);
		queue_request(KIND_OBTAIN, 8'hFF);
		queue_request(KIND_RELEASE, 8'hFF);
		queue_request(KIND_RELEASE, 8'h00);
		queue_request(KIND_OBTAIN, 8'h00);
		queue_request(KIND_OBTAIN, 8'h00);
		queue_request(KIND_FREE_ALL, 8'hFF);
		queue_request(KIND_OBTAIN, 8'h00);
		queue_request(KIND_RELEASE, 8'h55);
		queue_request(KIND_RELEASE, 8'h55);

		// single handle pool
		set_pool_size(9'd1);
		queue_request(KIND_OBTAIN, 8'h00);
		queue_request(KIND_OBTAIN, 8'h00);
		queue_request(KIND_RELEASE, 8'h80);

		// empty pool
		set_pool_size(9'd0);
		queue_request(KIND_OBTAIN, 8'h00);
		queue_request(KIND_RELEASE, 8'h01);

		// pool shrunk below the count in use
		set_pool_size(9'd8);
		repeat (4) queue_request(KIND_OBTAIN, 8'h00);
		set_pool_size(9'd2);
		queue_request(KIND_OBTAIN, 8'h00);
		queue_request(KIND_RELEASE, 8'h7F);
		queue_request(KIND_RELEASE, 8'hFE);
		queue_request(KIND_OBTAIN, 8'h00);
		queue_request(KIND_RELEASE, 8'h33);
		queue_request(KIND_OBTAIN, 8'h00);

		// random phases, stack state carried across pool size changes
		for (int p = 0; p < PHASES; p++) begin
			set_pool_size(size_plan[p]);
			if (p >= PHASES - 2) idle_en = 1'b0;
			if (size_plan[p] > POOL_DEPTH_DEF) begin
				queue_request(KIND_FREE_ALL, 8'h00);
				repeat (POOL_DEPTH_DEF + 2) queue_request(KIND_OBTAIN,
					HANDLE_W'($urandom_range(0, 255)));
			end
			if (p == 5) hold_token++;
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) begin
				seg_len = $urandom_range(1, 40);
				queue_segment(seg_len, lean_t'($urandom_range(0, 2)));
				phase_count += seg_len;
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("checked %0d transactions across %0d pool size writes", checked_ok, cfg_writes);
		$display("exhausted obtains %0d, releases with none outstanding %0d",
			exhausted_seen, underflow_seen);
		if (fail_count == 0) begin
			$display("handle_pool_free_stack_unit verification clean");
		end else begin
			$display("handle_pool_free_stack_unit verification failed");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("timeout at %0t ns with %0d results outstanding", $time, pending_grants.size());
		$display("handle_pool_free_stack_unit verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/hps_pkg.sv
rtl/hps_if.sv
rtl/handle_pool_free_stack_unit.sv
sim/handle_pool_free_stack_unit_tb.sv
